[rtl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Types and character constants shared by the URL percent decoder modules.
// ----------------------------------------------------------------------------
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DIG_0   = 8'h30;
   localparam logic [7:0] CH_DIG_9   = 8'h39;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_F    = 8'h46;
   localparam logic [7:0] CH_LO_A    = 8'h61;
   localparam logic [7:0] CH_LO_F    = 8'h66;

   localparam int unsigned GROUP_MAX = 3;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } upd_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } upd_rsp_type;

   // One accepted input byte worth of decoded output: 0..3 bytes (1..3 when queued)
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] data;
      logic [1:0]                count;
      logic                      last;
   } upd_group_type;

   typedef enum logic [1:0] {
      HELD_NONE  = 2'd0,
      HELD_PCT   = 2'd1,
      HELD_DIGIT = 2'd2
   } upd_held_type;

endpackage

[rtl/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front
// Classifies each input byte against the held escape state and forms the
// group of decoded bytes it produces, pushing non-empty groups to the queue.
// ----------------------------------------------------------------------------
module upd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  upd_pkg::upd_req_type  req_data,
   input  logic                  queue_full,
   output logic                  push_valid,
   output upd_pkg::upd_group_type push_data
);
   import upd_pkg::*;

   upd_held_type held_ff, held_in;
   logic [3:0]   nibble_ff, nibble_in;
   logic [7:0]   digit_ff, digit_in;

   logic         accept;
   logic         is_hex;
   logic [3:0]   hex_val;
   logic         fresh_hold;
   logic [7:0]   fresh_char;
   upd_group_type group;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (req_data.in_char >= CH_DIG_0 && req_data.in_char <= CH_DIG_9) begin
         hex_val = 4'(req_data.in_char - CH_DIG_0);
      end else if (req_data.in_char >= CH_UP_A && req_data.in_char <= CH_UP_F) begin
         hex_val = 4'(req_data.in_char - CH_UP_A + 8'd10);
      end else if (req_data.in_char >= CH_LO_A && req_data.in_char <= CH_LO_F) begin
         hex_val = 4'(req_data.in_char - CH_LO_A + 8'd10);
      end else begin
         is_hex = 1'b0;
      end
   end

   // Plain decode of the current byte with nothing held
   assign fresh_hold = (req_data.in_char == CH_PERCENT) && !req_data.in_last;
   assign fresh_char = (req_data.in_char == CH_PLUS) ? CH_SPACE : req_data.in_char;

   always_comb begin
      held_in    = held_ff;
      nibble_in  = nibble_ff;
      digit_in   = digit_ff;
      group      = '0;
      group.last = req_data.in_last;
      case (held_ff)
         HELD_PCT: begin
            if (is_hex && !req_data.in_last) begin
               held_in   = HELD_DIGIT;
               nibble_in = hex_val;
               digit_in  = req_data.in_char;
            end else begin
               group.data[0] = CH_PERCENT;
               if (fresh_hold) begin
                  held_in     = HELD_PCT;
                  group.count = 2'd1;
               end else begin
                  held_in       = HELD_NONE;
                  group.data[1] = fresh_char;
                  group.count   = 2'd2;
               end
            end
         end
         HELD_DIGIT: begin
            if (is_hex) begin
               held_in       = HELD_NONE;
               group.data[0] = {nibble_ff, hex_val};
               group.count   = 2'd1;
            end else begin
               group.data[0] = CH_PERCENT;
               group.data[1] = digit_ff;
               if (fresh_hold) begin
                  held_in     = HELD_PCT;
                  group.count = 2'd2;
               end else begin
                  held_in       = HELD_NONE;
                  group.data[2] = fresh_char;
                  group.count   = 2'd3;
               end
            end
         end
         default: begin
            if (fresh_hold) begin
               held_in = HELD_PCT;
            end else begin
               held_in       = HELD_NONE;
               group.data[0] = fresh_char;
               group.count   = 2'd1;
            end
         end
      endcase
   end

   assign push_valid = accept && (group.count != 2'd0);
   assign push_data  = group;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= HELD_NONE;
         nibble_ff <= 4'd0;
         digit_ff  <= 8'd0;
      end else if (accept) begin
         held_ff   <= held_in;
         nibble_ff <= nibble_in;
         digit_ff  <= digit_in;
      end
   end

endmodule

[rtl/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue
// Small register FIFO of decoded byte groups between front and back.
// ----------------------------------------------------------------------------
module upd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  upd_pkg::upd_group_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output upd_pkg::upd_group_type head_data
);
   import upd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   upd_group_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && !full;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back
// Replays the bytes of the head group one per beat into the output register.
// ----------------------------------------------------------------------------
module upd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  upd_pkg::upd_group_type head_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output upd_pkg::upd_rsp_type   rsp_data
);
   import upd_pkg::*;

   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   upd_rsp_type rsp_data_ff, rsp_data_in;
   logic        load;
   logic        final_byte;
   logic [7:0]  cur_char;

   assign load       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign final_byte = ((idx_ff + 2'd1) == head_data.count);
   assign pop        = load && final_byte;

   always_comb begin
      case (idx_ff)
         2'd0:    cur_char = head_data.data[0];
         2'd1:    cur_char = head_data.data[1];
         2'd2:    cur_char = head_data.data[2];
         default: cur_char = head_data.data[0];
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_char = cur_char;
         rsp_data_in.out_last = final_byte && head_data.last;
         idx_in               = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload while stalled
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder: %XX to one byte, plus to space.
//
//   channel   direction  payload                  handshake
//   req_      in         in_char[7:0], in_last    req_valid / req_stall
//   rsp_      out        out_char[7:0], out_last  rsp_valid / rsp_stall
//
// One input byte is accepted per cycle while the group queue has room.
// Each byte yields 0 to 3 output bytes; the back end emits one per cycle
// while rsp_stall is low, so the output rate of one byte per cycle sets the
// sustained throughput. Accepted bytes pass the queue and output register.
// Reset is synchronous and clears the held escape state and the queue.
// req_stall rises only when QUEUE_DEPTH groups are waiting on the back end.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  upd_pkg::upd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output upd_pkg::upd_rsp_type rsp_data
);
   import upd_pkg::*;

   logic          queue_full;
   logic          push_valid;
   upd_group_type push_data;
   logic          pop;
   logic          head_valid;
   upd_group_type head_data;

   upd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for url_percent_decoder. The bench decodes every
// accepted byte itself and keeps the bytes it should produce in a queue.
// Each output beat is checked against the head of that queue. A short
// directed part covers extreme bytes, good escapes and broken escapes. Random
// strings follow, most of them built from well-formed escapes. Sender gaps
// and receiver stalls are drawn at random, and some phases have none.
// ----------------------------------------------------------------------------
module tb;
   import upd_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned TAIL_CYCLES    = 20;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   upd_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   upd_rsp_type rsp_data;

   upd_rsp_type  decoded_q[$];
   upd_held_type held_state  = HELD_NONE;
   logic [3:0]   held_nibble = '0;
   logic [7:0]   held_char   = '0;

   int mismatches    = 0;
   int send_gap_max  = 19;
   int recv_gap_max  = 19;
   int stall_left    = 0;
   int quiet_cycles  = 0;

   url_percent_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Decoder prediction
   // ------------------------------------------------------------------------
   // Digit value 0..15, or 16 when ch is not a hex digit
   function automatic logic [4:0] hex_digit_value(input logic [7:0] ch);
      if (ch >= CH_DIG_0 && ch <= CH_DIG_9) return 5'(ch - CH_DIG_0);
      if (ch >= CH_UP_A && ch <= CH_UP_F) return 5'(ch - CH_UP_A + 8'd10);
      if (ch >= CH_LO_A && ch <= CH_LO_F) return 5'(ch - CH_LO_A + 8'd10);
      return 5'd16;
   endfunction

   function automatic void push_decoded(input logic [7:0] ch, input logic last);
      decoded_q.insert(decoded_q.size(), upd_rsp_type'{out_char: ch, out_last: last});
   endfunction

   // Decode one byte with no escape pending
   function automatic void decode_plain(input logic [7:0] ch, input logic last);
      if (ch == CH_PERCENT) begin
         if (last) push_decoded(CH_PERCENT, 1'b1);
         else held_state = HELD_PCT;
      end else if (ch == CH_PLUS) begin
         push_decoded(CH_SPACE, last);
      end else begin
         push_decoded(ch, last);
      end
   endfunction

   function automatic void decode_byte(input logic [7:0] ch, input logic last);
      logic [4:0] digit;
      digit = hex_digit_value(ch);
      case (held_state)
         HELD_PCT: begin
            if (!digit[4] && !last) begin
               held_char   = ch;
               held_nibble = digit[3:0];
               held_state  = HELD_DIGIT;
            end else begin
               held_state = HELD_NONE;
               push_decoded(CH_PERCENT, 1'b0);
               decode_plain(ch, last);
            end
         end
         HELD_DIGIT: begin
            held_state = HELD_NONE;
            if (!digit[4]) begin
               push_decoded({held_nibble, digit[3:0]}, last);
            end else begin
               // replay the percent and the held digit, then the new byte
               push_decoded(CH_PERCENT, 1'b0);
               decode_plain(held_char, 1'b0);
               decode_plain(ch, last);
            end
         end
         default: begin
            held_state = HELD_NONE;
            decode_plain(ch, last);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Output checking and receiver stalls
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      upd_rsp_type want;
      if (rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat: expected none, actual char %h last %b",
                     $time, rsp_data.out_char, rsp_data.out_last);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_data.out_char !== want.out_char) begin
               mismatches++;
               $display("%0t: out_char mismatch: expected %h, actual %h",
                        $time, want.out_char, rsp_data.out_char);
            end
            if (rsp_data.out_last !== want.out_last) begin
               mismatches++;
               $display("%0t: out_last mismatch: expected %b, actual %b",
                        $time, want.out_last, rsp_data.out_last);
            end
         end
         stall_left = $urandom_range(0, recv_gap_max);
      end else if (rsp_valid && stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   // End the run when neither channel moves a beat for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] ch, input logic last);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= upd_req_type'{in_char: ch, in_last: last};
      do @(posedge clock); while (req_stall);
      decode_byte(ch, last);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], i == text.len() - 1);
   endtask

   // Hold the sender until every decoded byte has come out
   task automatic wait_for_decoded_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_q.size() != 0);
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [3:0] value;
      value = 4'($urandom_range(0, 15));
      if (value < 10) return CH_DIG_0 + 8'(value);
      if ($urandom_range(0, 1)) return CH_UP_A + 8'(value - 10);
      return CH_LO_A + 8'(value - 10);
   endfunction

   task automatic send_random_string(output int sent);
      logic [7:0] text[$];
      int         len;
      int         kind;
      len = $urandom_range(1, 12);
      while (text.size() < len) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            text.insert(text.size(), CH_PERCENT);
            text.insert(text.size(), random_hex_char());
            text.insert(text.size(), random_hex_char());
         end else if (kind < 45) begin
            text.insert(text.size(), CH_PERCENT);
         end else if (kind < 60) begin
            text.insert(text.size(), random_hex_char());
         end else if (kind < 66) begin
            text.insert(text.size(), CH_PLUS);
         end else begin
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      sent = text.size();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_PLUS, 1'b0);
      send_byte(8'h78, 1'b1);
   endtask

   task automatic test_good_escapes();
      send_text("%4a%FF");
      send_text("%00+");
   endtask

   task automatic test_broken_escapes();
      send_text("%");      // percent on the last byte
      send_text("%4");     // percent and one digit, then the string ends
      send_text("%%41");   // bad first digit starts a new escape
      send_text("%4%A+");  // bad second digit, then a truncated escape
   endtask

   task automatic test_random_traffic(input int n_items, input int s_max, input int r_max);
      int count;
      int sent;
      send_gap_max = s_max;
      recv_gap_max = r_max;
      count = 0;
      while (count < n_items) begin
         send_random_string(sent);
         count += sent;
      end
   endtask

   task automatic test_drain_pause();
      int sent;
      send_gap_max = 19;
      recv_gap_max = 19;
      // pause with an escape half received
      send_byte(CH_PERCENT, 1'b0);
      wait_for_decoded_drain();
      send_byte(8'h34, 1'b0);
      wait_for_decoded_drain();
      send_byte(8'h31, 1'b1);
      repeat (6) begin
         send_random_string(sent);
         wait_for_decoded_drain();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_good_escapes();
      test_broken_escapes();
      test_random_traffic(140, 19, 19);
      test_random_traffic(70, 0, 0);
      test_random_traffic(70, 0, 19);
      test_random_traffic(70, 19, 0);
      test_drain_pause();

      wait_for_decoded_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
